FILE: src/tequ_pkg.sv
// Package for the touch event queue endpoint.
// Holds the operation and response codes, the queue entry layout and the
// command passed from the queue control to the report stage. No dependencies.
package tequ_pkg;

	// Operation codes carried in the request.
	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_IN    = 2'd1,
		OP_OTHER = 2'd2,
		OP_RESET = 2'd3
	} op_t;

	// Handshake response codes returned with each result.
	typedef enum logic [1:0] {
		RSP_NONE  = 2'd0,
		RSP_DATA  = 2'd1,
		RSP_NAK   = 2'd2,
		RSP_STALL = 2'd3
	} rsp_t;

	// The only endpoint that carries touch reports.
	localparam logic [3:0] DATA_EP = 4'd1;

	// Field widths of the stream payloads.
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 64;

	// One queued touch event, 56 bits.
	typedef struct packed {
		logic [7:0]  buttons;
		logic [15:0] id;
		logic [15:0] y;
		logic [15:0] x;
	} entry_t;

	// Decoded request handed to the report stage.
	typedef struct packed {
		rsp_t rsp;
		logic dropped;
		logic pop;
		logic len_ok;
		logic clear;
	} cmd_t;

endpackage

FILE: src/tequ_mem.sv
// Event store for the touch event queue: one write port, one read port.
// Read data is registered, so it appears in the cycle after the read enable.
// Depends on tequ_pkg for the entry layout.
module tequ_mem #(
	parameter int unsigned DEPTH = 128,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  tequ_pkg::entry_t     wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output tequ_pkg::entry_t     rd_data
);
	import tequ_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/tequ_ctrl.sv
// Queue control for the touch event queue: decodes each request, keeps the
// read and write pointers, the fill count and the pending flag, and drives
// the event store ports. Depends on tequ_pkg.
module tequ_ctrl #(
	parameter int unsigned QUEUE_DEPTH  = 128,
	parameter int unsigned PACKET_BYTES = 8,
	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Request side.
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           operation,
	input  logic [3:0]           endpoint,
	input  logic [9:0]           buffer_len,
	input  tequ_pkg::entry_t     event_in,
	// Event store ports.
	output logic                 wr_en,
	output logic [PTR_W-1:0]     wr_addr,
	output tequ_pkg::entry_t     wr_data,
	output logic                 rd_en,
	output logic [PTR_W-1:0]     rd_addr,
	// Command toward the report stage.
	output logic                 cmd_valid_s1,
	output tequ_pkg::cmd_t       cmd_s1,
	input  logic                 cmd_ready
);
	import tequ_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [10:0] PKT_LEN = 11'(PACKET_BYTES);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             pending_q, pending_d;
	logic             accept;
	logic             push, pop;
	cmd_t             cmd_d;

	assign req_ready = !cmd_valid_s1 || cmd_ready;
	assign accept    = req_valid && req_ready;

	// Decode the request and work out the next queue bookkeeping.
	always_comb begin
		rd_ptr_d      = rd_ptr_q;
		wr_ptr_d      = wr_ptr_q;
		count_d       = count_q;
		pending_d     = pending_q;
		push          = 1'b0;
		pop           = 1'b0;
		cmd_d.rsp     = RSP_NONE;
		cmd_d.dropped = 1'b0;
		cmd_d.pop     = 1'b0;
		cmd_d.len_ok  = (11'(buffer_len) >= PKT_LEN);
		cmd_d.clear   = 1'b0;
		case (op_t'(operation))
			OP_EVENT: begin
				if (count_q == FULL_CNT) begin
					cmd_d.dropped = 1'b1;
				end else begin
					push      = 1'b1;
					wr_ptr_d  = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
					count_d   = count_q + 1'b1;
					pending_d = 1'b1;
				end
			end
			OP_RESET: begin
				rd_ptr_d    = '0;
				wr_ptr_d    = '0;
				count_d     = '0;
				cmd_d.clear = 1'b1;
			end
			OP_IN: begin
				if (endpoint != DATA_EP) begin
					cmd_d.rsp = RSP_STALL;
				end else if (!pending_q) begin
					cmd_d.rsp = RSP_NAK;
				end else begin
					cmd_d.rsp = RSP_DATA;
					if (count_q != '0) begin
						pop       = 1'b1;
						cmd_d.pop = 1'b1;
						rd_ptr_d  = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
						count_d   = count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							pending_d = 1'b0;
						end
					end else begin
						pending_d = 1'b0;
					end
				end
			end
			default: begin
				cmd_d.rsp = RSP_STALL;
			end
		endcase
	end

	// Event store accesses happen at the accept edge.
	assign wr_en   = accept && push;
	assign wr_addr = wr_ptr_q;
	assign wr_data = event_in;
	assign rd_en   = accept && pop;
	assign rd_addr = rd_ptr_q;

	// Queue bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			pending_q <= 1'b1;
		end else if (accept) begin
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			count_q   <= count_d;
			pending_q <= pending_d;
		end
	end

	// Stage 1 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			cmd_valid_s1 <= req_valid;
		end
	end

	// Stage 1 command payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

FILE: src/tequ_report.sv
// Report stage for the touch event queue: holds the last report, merges in
// a popped entry from the event store and drives the result register.
// Depends on tequ_pkg.
module tequ_report #(
	parameter int unsigned PACKET_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid_s1,
	input  tequ_pkg::cmd_t                cmd_s1,
	output logic                          cmd_ready,
	input  tequ_pkg::entry_t              rd_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tequ_pkg::OUT_DATA_W-1:0] out_data
);
	import tequ_pkg::*;

	localparam logic [7:0] PKT_LEN = 8'(PACKET_BYTES);

	entry_t                last_q;
	entry_t                src;
	logic                  advance;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_DATA_W-1:0] out_data_d;

	assign cmd_ready = !out_valid_q || out_ready;
	assign advance   = cmd_valid_s1 && cmd_ready;

	// A pop reports the fresh entry; otherwise the last report is sent again.
	assign src = cmd_s1.pop ? rd_data : last_q;

	// Pack the result: response, dropped, x, y, id, touched, length.
	always_comb begin
		out_data_d        = '0;
		out_data_d[1:0]   = cmd_s1.rsp;
		out_data_d[2]     = cmd_s1.dropped;
		if (cmd_s1.rsp == RSP_DATA && cmd_s1.len_ok) begin
			out_data_d[18:3]  = src.x;
			out_data_d[34:19] = src.y;
			out_data_d[50:35] = src.id;
			out_data_d[51]    = (src.buttons != 8'd0);
			out_data_d[59:52] = PKT_LEN;
		end
	end

	// Last report registers, updated in request order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (advance) begin
			if (cmd_s1.clear) begin
				last_q <= '0;
			end else if (cmd_s1.pop) begin
				last_q <= rd_data;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_ready) begin
			out_valid_q <= cmd_valid_s1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= out_data_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: src/touch_event_queue_usb_endpoint.sv
// Touch event queue behind a USB interrupt IN endpoint.
// Each request passes through the stage 1 command and the result registers.
// One request per cycle unless the output stalls; the event store is read at
// the accept edge; its registered data is merged when the command advances.
// Reset clears pointers, fill count and last report and sets the pending
// flag; the event store itself is not cleared and needs no clearing pass.
module touch_event_queue_usb_endpoint #(
	parameter int unsigned QUEUE_DEPTH  = 128,
	parameter int unsigned PACKET_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// Fields from bit 0: operation, endpoint, buffer_len, touch_x, touch_y,
	// contact_id, buttons.
	input  logic [tequ_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// Fields from bit 0: response, dropped, report_x, report_y, report_id,
	// touched, report_len, then zero fill.
	output logic [tequ_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tequ_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	entry_t           event_in;
	entry_t           rd_data;
	entry_t           wr_data;
	logic             wr_en, rd_en;
	logic [PTR_W-1:0] wr_addr, rd_addr;
	logic             cmd_valid_s1, cmd_ready;
	cmd_t             cmd_s1;

	// Unpack the touch event fields.
	assign event_in.x       = s_axis_tdata[31:16];
	assign event_in.y       = s_axis_tdata[47:32];
	assign event_in.id      = s_axis_tdata[63:48];
	assign event_in.buttons = s_axis_tdata[71:64];

	tequ_ctrl #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PACKET_BYTES (PACKET_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (s_axis_tvalid),
		.req_ready    (s_axis_tready),
		.operation    (s_axis_tdata[1:0]),
		.endpoint     (s_axis_tdata[5:2]),
		.buffer_len   (s_axis_tdata[15:6]),
		.event_in     (event_in),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.cmd_valid_s1 (cmd_valid_s1),
		.cmd_s1       (cmd_s1),
		.cmd_ready    (cmd_ready)
	);

	tequ_mem #(
		.DEPTH (QUEUE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tequ_report #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid_s1 (cmd_valid_s1),
		.cmd_s1       (cmd_s1),
		.cmd_ready    (cmd_ready),
		.rd_data      (rd_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata)
	);

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the touch event queue endpoint: streams events, tokens and bus
// resets into the block and checks every report against its own queue model.
// Depends on tequ_pkg and touch_event_queue_usb_endpoint.
module tb;
	import tequ_pkg::*;

	localparam int unsigned QUEUE_DEPTH  = 128;
	localparam int unsigned PACKET_BYTES = 8;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned HOLD_AT      = 200;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 10;

	// Request layout, bit 0 first: operation, endpoint, buffer_len, touch_x,
	// touch_y, contact_id, buttons.
	typedef struct packed {
		logic [7:0]  buttons;
		logic [15:0] id;
		logic [15:0] y;
		logic [15:0] x;
		logic [9:0]  blen;
		logic [3:0]  ep;
		op_t         op;
	} touch_req_t;

	// Report layout, bit 0 first: response, dropped, report_x, report_y,
	// report_id, touched, report_len, zero fill.
	typedef struct packed {
		logic [3:0]  fill;
		logic [7:0]  len;
		logic        touched;
		logic [15:0] id;
		logic [15:0] y;
		logic [15:0] x;
		logic        dropped;
		rsp_t        response;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Model state of the queue and the last report.
	entry_t touch_fifo[$];
	entry_t last_report;
	logic pend_flag;

	touch_req_t pending_requests[$];
	report_t expected_reports[$];
	logic in_taken;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned reports_seen;
	int unsigned err_count;
	int unsigned hold_left;
	logic hold_done;
	int unsigned mode_left;
	int unsigned ready_mode;
	int unsigned cycle_count;

	touch_event_queue_usb_endpoint #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PACKET_BYTES(PACKET_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the report for one request and advances the queue model.
	function automatic report_t predict_report(touch_req_t req);
		report_t res;
		entry_t ent;
		res = '0;
		res.response = RSP_NONE;
		if (req.op == OP_EVENT) begin
			if (touch_fifo.size() >= QUEUE_DEPTH) begin
				res.dropped = 1'b1;
			end else begin
				ent.x = req.x;
				ent.y = req.y;
				ent.id = req.id;
				ent.buttons = req.buttons;
				touch_fifo.push_back(ent);
				pend_flag = 1'b1;
			end
		end else if (req.op == OP_RESET) begin
			// Bus reset empties the queue but leaves the pending flag alone.
			last_report = '0;
			touch_fifo.delete();
		end else if (req.op != OP_IN || req.ep != DATA_EP) begin
			res.response = RSP_STALL;
		end else if (!pend_flag) begin
			res.response = RSP_NAK;
		end else begin
			// With an empty queue the previous report is sent again.
			if (touch_fifo.size() != 0) begin
				last_report = touch_fifo.pop_front();
				if (touch_fifo.size() == 0)
					pend_flag = 1'b0;
			end else begin
				pend_flag = 1'b0;
			end
			res.response = RSP_DATA;
			if (req.blen >= PACKET_BYTES) begin
				res.x = last_report.x;
				res.y = last_report.y;
				res.id = last_report.id;
				res.touched = (last_report.buttons != 8'd0);
				res.len = 8'(PACKET_BYTES);
			end
		end
		return res;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			err_count++;
		end
	endtask

	// Accepted requests feed the model at the rising edge.
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_reports.push_back(predict_report(touch_req_t'(s_axis_tdata)));
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				s_axis_tdata <= pending_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switches among random stall patterns, and once
	// holds off long enough for the block to back up into its input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 80);
				ready_mode = $urandom_range(0, 2);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && reports_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (ready_mode == 0) begin
				m_axis_tready <= 1'b1;
			end else if (ready_mode == 1) begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end else begin
				m_axis_tready <= ($urandom_range(0, 1) != 0);
			end
		end
	end

	// Each report is compared with the oldest expectation.
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = report_t'(m_axis_tdata);
			reports_seen <= reports_seen + 1;
			if (expected_reports.size() == 0) begin
				$error("unexpected report: %0h", m_axis_tdata);
				err_count++;
			end else begin
				want = expected_reports.pop_front();
				check_field("response", 16'(want.response), 16'(got.response));
				check_field("dropped", 16'(want.dropped), 16'(got.dropped));
				check_field("report_x", want.x, got.x);
				check_field("report_y", want.y, got.y);
				check_field("report_id", want.id, got.id);
				check_field("touched", 16'(want.touched), 16'(got.touched));
				check_field("report_len", 16'(want.len), 16'(got.len));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_req(op_t op, logic [3:0] ep, logic [9:0] blen, logic [15:0] x,
			logic [15:0] y, logic [15:0] id, logic [7:0] buttons);
		touch_req_t req;
		req.op = op;
		req.ep = ep;
		req.blen = blen;
		req.x = x;
		req.y = y;
		req.id = id;
		req.buttons = buttons;
		pending_requests.push_back(req);
	endtask

	// Same request with random event content; buttons are often all clear.
	task automatic queue_rand(op_t op, logic [3:0] ep, logic [9:0] blen);
		logic [7:0] buttons;
		buttons = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		queue_req(op, ep, blen, 16'($urandom), 16'($urandom), 16'($urandom), buttons);
	endtask

	// Mostly a full packet fits; now and then the host buffer is short.
	function automatic logic [9:0] pick_blen();
		if ($urandom_range(0, 4) == 0)
			return 10'($urandom_range(0, PACKET_BYTES - 1));
		return 10'($urandom_range(PACKET_BYTES, 1023));
	endfunction

	function automatic logic [3:0] other_ep();
		logic [3:0] ep;
		ep = 4'($urandom_range(0, 14));
		if (ep >= DATA_EP)
			ep++;
		return ep;
	endfunction

	// Runs of events followed by roughly as many IN tokens, with some noise.
	task automatic queue_mix(int unsigned n);
		int unsigned target;
		int unsigned k;
		target = pending_requests.size() + n;
		while (pending_requests.size() < target) begin
			k = $urandom_range(1, 8);
			repeat (k) queue_rand(OP_EVENT, 4'($urandom), pick_blen());
			repeat ($urandom_range((k > 2) ? k - 2 : 1, k + 2))
				queue_rand(OP_IN, DATA_EP, pick_blen());
			case ($urandom_range(0, 9))
				0: queue_rand(OP_OTHER, 4'($urandom), pick_blen());
				1: queue_rand(OP_IN, other_ep(), pick_blen());
				2: if ($urandom_range(0, 3) == 0)
					queue_rand(OP_RESET, 4'($urandom), pick_blen());
				default: ;
			endcase
		end
	endtask

	// Queues a flood of events that can overfill the queue, then IN tokens to read it back.
	task automatic queue_flood(int unsigned n_events, int unsigned n_ins);
		repeat (n_events) queue_rand(OP_EVENT, 4'($urandom), pick_blen());
		repeat (n_ins) queue_rand(OP_IN, DATA_EP, pick_blen());
	endtask

	// The test sequence pauses here until every expected report has come back.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		in_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		reports_seen = 0;
		err_count = 0;
		hold_left = 0;
		hold_done = 1'b0;
		mode_left = 0;
		ready_mode = 0;
		cycle_count = 0;
		touch_fifo.delete();
		last_report = '0;
		pend_flag = 1'b1;

		// Directed part. After reset the flag is set with an empty queue, so
		// the cleared report goes out once and the next IN is refused.
		queue_req(OP_IN, DATA_EP, 10'd8, 16'h1111, 16'h2222, 16'h3333, 8'h44);
		queue_req(OP_IN, DATA_EP, 10'd1023, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		queue_req(OP_EVENT, 4'hf, 10'd1023, 16'hffff, 16'h0000, 16'hffff, 8'hff);
		queue_req(OP_EVENT, 4'h0, 10'd0, 16'h0000, 16'hffff, 16'h0000, 8'h00);
		queue_req(OP_EVENT, 4'h5, 10'd9, 16'h1234, 16'h5678, 16'h9abc, 8'h80);
		queue_req(OP_IN, DATA_EP, 10'd8, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		// Short buffers still pop but carry an empty report.
		queue_req(OP_IN, DATA_EP, 10'd7, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		queue_req(OP_IN, DATA_EP, 10'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		queue_req(OP_IN, DATA_EP, 10'd1023, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		// Tokens that must stall.
		queue_req(OP_IN, 4'h0, 10'd64, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		queue_req(OP_IN, 4'hf, 10'd64, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		queue_req(OP_OTHER, DATA_EP, 10'd64, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		queue_req(OP_OTHER, 4'h0, 10'd1023, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		// Bus reset with an event queued keeps the flag set and clears the report.
		queue_req(OP_EVENT, 4'h3, 10'd12, 16'haaaa, 16'h5555, 16'h0f0f, 8'h01);
		queue_req(OP_RESET, 4'h0, 10'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		queue_req(OP_IN, DATA_EP, 10'd8, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		queue_req(OP_IN, DATA_EP, 10'd8, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		queue_req(OP_EVENT, 4'h1, 10'd8, 16'h0101, 16'h0202, 16'h0303, 8'h02);
		queue_req(OP_EVENT, 4'h1, 10'd8, 16'h0404, 16'h0505, 16'h0606, 8'h00);
		queue_req(OP_RESET, 4'hf, 10'd1023, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		queue_req(OP_EVENT, 4'h2, 10'd3, 16'hbeef, 16'hcafe, 16'hf00d, 8'h00);
		queue_req(OP_IN, DATA_EP, 10'd255, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		queue_req(OP_IN, DATA_EP, 10'd8, 16'h0000, 16'h0000, 16'h0000, 8'h00);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait_drained();
		queue_mix(600);
		wait_drained();
		// Overflow the queue, read it all back and send three more IN tokens.
		queue_flood(QUEUE_DEPTH + 12, QUEUE_DEPTH + 3);
		wait_drained();
		queue_mix(300);
		queue_flood(QUEUE_DEPTH + 4, 0);
		queue_rand(OP_RESET, 4'($urandom), pick_blen());
		repeat (3) queue_rand(OP_IN, DATA_EP, pick_blen());
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
src/tequ_pkg.sv
src/tequ_mem.sv
src/tequ_ctrl.sv
src/tequ_report.sv
src/touch_event_queue_usb_endpoint.sv
test/tb.sv
